// File: rtl/gsm_pkg.sv
package gsm_pkg;

  localparam int SLOT_COUNT  = 1024;
  localparam int DENSE_DEPTH = 1024;
  localparam int SLOT_W      = 10;
  localparam int POS_W       = 10;
  localparam int GEN_W       = 16;
  localparam int CNT_W       = 11;
  localparam int VAL_W       = 32;

  localparam logic [CNT_W-1:0] LINK_NONE  = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] SLOT_FULL  = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] DENSE_FULL = CNT_W'(DENSE_DEPTH);
  localparam logic [GEN_W-1:0] GEN_MAX    = '1;
  localparam logic [GEN_W-1:0] GEN_FIRST  = GEN_W'(1);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_ERASE = 2'd2,
    FUNC_SWAP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_W-1:0]       handle_slot;
    logic [GEN_W-1:0]        handle_generation;
    logic [POS_W-1:0]        pos_a;
    logic [POS_W-1:0]        pos_b;
  } item_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_W-1:0]       out_slot;
    logic [GEN_W-1:0]        out_generation;
    logic signed [VAL_W-1:0] out_value;
    logic [CNT_W-1:0]        live_count;
  } result_t;

endpackage

// File: rtl/generational_slot_map_core.sv
// An accepted item steps through its states to ST_DONE, which registers the result beat:
// add via ST_ADD_WR; get via ST_GET_CHK, ST_GET_VAL; erase via ST_ER_CHK, ST_ER_MOVE; swap
// via ST_SW_RDB, ST_SW_WRA, ST_SW_WRB; a rejected item goes straight there. Results wait
// on stall. One item at a time, paced by the single registered read port of each RAM.
// Reset: synchronous; clears counters, free list head and handshake state.
// No clearing pass: slots at or above the fresh-slot count are never read.
module generational_slot_map_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  gsm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output gsm_pkg::result_t result
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_ADD_WR  = 12'b0000_0000_0010,
    ST_GET_CHK = 12'b0000_0000_0100,
    ST_GET_VAL = 12'b0000_0000_1000,
    ST_ER_CHK  = 12'b0000_0001_0000,
    ST_ER_MOVE = 12'b0000_0010_0000,
    ST_SW_RDB  = 12'b0000_0100_0000,
    ST_SW_WRA  = 12'b0000_1000_0000,
    ST_SW_WRB  = 12'b0001_0000_0000,
    ST_DONE    = 12'b0010_0000_0000
  } state_t;

  state_t                          state;
  gsm_pkg::item_t                  req;
  gsm_pkg::result_t                res;
  logic [gsm_pkg::CNT_W-1:0]       entry_count;
  logic [gsm_pkg::CNT_W-1:0]       slots_in_use;
  logic [gsm_pkg::CNT_W-1:0]       free_head;
  logic [gsm_pkg::SLOT_W-1:0]      add_id;
  logic                            add_fresh;
  logic [gsm_pkg::POS_W-1:0]       epos;
  logic [gsm_pkg::POS_W-1:0]       elast;
  logic [gsm_pkg::VAL_W-1:0]       va;
  logic [gsm_pkg::SLOT_W-1:0]      oa;

  // slot RAMs: {live, pos}, generation, free link
  logic                            sp_we, sg_we, sl_we;
  logic [gsm_pkg::SLOT_W-1:0]      sp_waddr, sg_waddr, sl_waddr, slot_raddr;
  logic [gsm_pkg::POS_W:0]         sp_wdata, sp_rdata;
  logic [gsm_pkg::GEN_W-1:0]       sg_wdata, sg_rdata;
  logic [gsm_pkg::CNT_W-1:0]       sl_wdata, sl_rdata;
  // dense RAMs: value, owner slot
  logic                            dn_we;
  logic [gsm_pkg::POS_W-1:0]       dn_waddr, dn_raddr;
  logic [gsm_pkg::VAL_W-1:0]       dv_wdata, dv_rdata;
  logic [gsm_pkg::SLOT_W-1:0]      do_wdata, do_rdata;

  logic                            accept;
  logic                            handle_ok;
  logic                            gen_retire;
  logic                            out_free;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign handle_ok  = sp_rdata[gsm_pkg::POS_W] && (sg_rdata == req.handle_generation);
  assign gen_retire = (sg_rdata == gsm_pkg::GEN_MAX);
  assign out_free   = !result_valid || !result_stall;
  assign slot_raddr = (item.func == gsm_pkg::FUNC_ADD) ? free_head[gsm_pkg::SLOT_W-1:0]
                                                       : item.handle_slot;

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = '0;
    sp_wdata = '0;
    sg_we    = 1'b0;
    sg_waddr = '0;
    sg_wdata = '0;
    sl_we    = 1'b0;
    sl_waddr = '0;
    sl_wdata = '0;
    dn_we    = 1'b0;
    dn_waddr = '0;
    dv_wdata = '0;
    do_wdata = '0;
    dn_raddr = item.pos_a;
    case (state)
      ST_ADD_WR: begin
        sp_we    = 1'b1;
        sp_waddr = add_id;
        sp_wdata = {1'b1, entry_count[gsm_pkg::POS_W-1:0]};
        sg_we    = add_fresh;
        sg_waddr = add_id;
        sg_wdata = gsm_pkg::GEN_FIRST;
        sl_we    = 1'b1;
        sl_waddr = add_id;
        sl_wdata = gsm_pkg::LINK_NONE;
        dn_we    = 1'b1;
        dn_waddr = entry_count[gsm_pkg::POS_W-1:0];
        dv_wdata = req.value;
        do_wdata = add_id;
      end
      ST_GET_CHK: begin
        dn_raddr = sp_rdata[gsm_pkg::POS_W-1:0];
      end
      ST_ER_CHK: begin
        dn_raddr = gsm_pkg::POS_W'(entry_count - gsm_pkg::CNT_W'(1));
        if (handle_ok) begin
          sp_we    = 1'b1;
          sp_waddr = req.handle_slot;
          sp_wdata = {1'b0, sp_rdata[gsm_pkg::POS_W-1:0]};
          sg_we    = !gen_retire;
          sg_waddr = req.handle_slot;
          sg_wdata = sg_rdata + gsm_pkg::GEN_W'(1);
          sl_we    = !gen_retire;
          sl_waddr = req.handle_slot;
          sl_wdata = free_head;
        end
      end
      ST_ER_MOVE: begin
        if (epos != elast) begin
          sp_we    = 1'b1;
          sp_waddr = do_rdata;
          sp_wdata = {1'b1, epos};
          dn_we    = 1'b1;
          dn_waddr = epos;
          dv_wdata = dv_rdata;
          do_wdata = do_rdata;
        end
      end
      ST_SW_RDB: begin
        dn_raddr = req.pos_b;
      end
      ST_SW_WRA: begin
        sp_we    = 1'b1;
        sp_waddr = do_rdata;
        sp_wdata = {1'b1, req.pos_a};
        dn_we    = 1'b1;
        dn_waddr = req.pos_a;
        dv_wdata = dv_rdata;
        do_wdata = do_rdata;
      end
      ST_SW_WRB: begin
        sp_we    = 1'b1;
        sp_waddr = oa;
        sp_wdata = {1'b1, req.pos_b};
        dn_we    = 1'b1;
        dn_waddr = req.pos_b;
        dv_wdata = va;
        do_wdata = oa;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      entry_count  <= '0;
      slots_in_use <= '0;
      free_head    <= gsm_pkg::LINK_NONE;
    end else begin
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req <= item;
            case (item.func)
              gsm_pkg::FUNC_ADD: begin
                if (entry_count >= gsm_pkg::DENSE_FULL) begin
                  res   <= '{status: gsm_pkg::ST_FULL, default: '0};
                  state <= ST_DONE;
                end else if (free_head != gsm_pkg::LINK_NONE) begin
                  res       <= '0;
                  add_id    <= free_head[gsm_pkg::SLOT_W-1:0];
                  add_fresh <= 1'b0;
                  state     <= ST_ADD_WR;
                end else if (slots_in_use < gsm_pkg::SLOT_FULL) begin
                  res       <= '0;
                  add_id    <= slots_in_use[gsm_pkg::SLOT_W-1:0];
                  add_fresh <= 1'b1;
                  state     <= ST_ADD_WR;
                end else begin
                  res   <= '{status: gsm_pkg::ST_FULL, default: '0};
                  state <= ST_DONE;
                end
              end
              gsm_pkg::FUNC_GET: begin
                if (gsm_pkg::CNT_W'(item.handle_slot) >= slots_in_use) begin
                  res   <= '{status: gsm_pkg::ST_STALE, default: '0};
                  state <= ST_DONE;
                end else begin
                  res   <= '0;
                  state <= ST_GET_CHK;
                end
              end
              gsm_pkg::FUNC_ERASE: begin
                if (gsm_pkg::CNT_W'(item.handle_slot) >= slots_in_use || entry_count == '0) begin
                  res   <= '{status: gsm_pkg::ST_STALE, default: '0};
                  state <= ST_DONE;
                end else begin
                  res   <= '0;
                  state <= ST_ER_CHK;
                end
              end
              default: begin
                if (gsm_pkg::CNT_W'(item.pos_a) >= entry_count ||
                    gsm_pkg::CNT_W'(item.pos_b) >= entry_count) begin
                  res   <= '{status: gsm_pkg::ST_RANGE, default: '0};
                  state <= ST_DONE;
                end else begin
                  res   <= '0;
                  state <= ST_SW_RDB;
                end
              end
            endcase
          end
        end
        ST_ADD_WR: begin
          if (add_fresh) begin
            slots_in_use       <= slots_in_use + gsm_pkg::CNT_W'(1);
            res.out_generation <= gsm_pkg::GEN_FIRST;
          end else begin
            free_head          <= sl_rdata;
            res.out_generation <= sg_rdata;
          end
          res.out_slot <= add_id;
          entry_count  <= entry_count + gsm_pkg::CNT_W'(1);
          state        <= ST_DONE;
        end
        ST_GET_CHK: begin
          if (handle_ok) begin
            state <= ST_GET_VAL;
          end else begin
            res.status <= gsm_pkg::ST_STALE;
            state      <= ST_DONE;
          end
        end
        ST_GET_VAL: begin
          res.out_value <= dv_rdata;
          state         <= ST_DONE;
        end
        ST_ER_CHK: begin
          if (handle_ok) begin
            epos  <= sp_rdata[gsm_pkg::POS_W-1:0];
            elast <= gsm_pkg::POS_W'(entry_count - gsm_pkg::CNT_W'(1));
            if (!gen_retire) begin
              free_head <= gsm_pkg::CNT_W'(req.handle_slot);
            end
            state <= ST_ER_MOVE;
          end else begin
            res.status <= gsm_pkg::ST_STALE;
            state      <= ST_DONE;
          end
        end
        ST_ER_MOVE: begin
          entry_count <= entry_count - gsm_pkg::CNT_W'(1);
          state       <= ST_DONE;
        end
        ST_SW_RDB: begin
          va    <= dv_rdata;
          oa    <= do_rdata;
          state <= ST_SW_WRA;
        end
        ST_SW_WRA: begin
          state <= ST_SW_WRB;
        end
        ST_SW_WRB: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            result       <= '{status: res.status, out_slot: res.out_slot,
                              out_generation: res.out_generation,
                              out_value: res.out_value, live_count: entry_count};
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  gsm_ram #(.WIDTH(gsm_pkg::POS_W + 1), .DEPTH(gsm_pkg::SLOT_COUNT)) u_slot_pos (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (slot_raddr),
    .rdata (sp_rdata)
  );

  gsm_ram #(.WIDTH(gsm_pkg::GEN_W), .DEPTH(gsm_pkg::SLOT_COUNT)) u_slot_gen (
    .clk   (clk),
    .we    (sg_we),
    .waddr (sg_waddr),
    .wdata (sg_wdata),
    .raddr (slot_raddr),
    .rdata (sg_rdata)
  );

  gsm_ram #(.WIDTH(gsm_pkg::CNT_W), .DEPTH(gsm_pkg::SLOT_COUNT)) u_slot_link (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (slot_raddr),
    .rdata (sl_rdata)
  );

  gsm_ram #(.WIDTH(gsm_pkg::VAL_W), .DEPTH(gsm_pkg::DENSE_DEPTH)) u_dense_val (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dv_wdata),
    .raddr (dn_raddr),
    .rdata (dv_rdata)
  );

  gsm_ram #(.WIDTH(gsm_pkg::SLOT_W), .DEPTH(gsm_pkg::DENSE_DEPTH)) u_dense_own (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (do_wdata),
    .raddr (dn_raddr),
    .rdata (do_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= gsm_pkg::DENSE_FULL && entry_count <= slots_in_use)
    else $error("live count exceeds capacity or slots handed out");

  a_free_head: assert property (@(posedge clk) disable iff (rst)
    free_head == gsm_pkg::LINK_NONE || free_head < slots_in_use)
    else $error("free list head points at a slot never handed out");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    entry_count != $past(entry_count) |->
      entry_count == $past(entry_count) + gsm_pkg::CNT_W'(1) ||
      entry_count == $past(entry_count) - gsm_pkg::CNT_W'(1))
    else $error("live count moved by more than one");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside the done state");

endmodule

// File: rtl/gsm_ram.sv
module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
